// ----- rtl/core/jtl_pkg.sv -----
// ----------------------------------------------------------------------------
// JSON token lexer package
// Shared types and constants for the lexer front end, request queue and
// back end.
// ----------------------------------------------------------------------------
package jtl_pkg;

    localparam logic [3:0] M_IDLE      = 4'd0;
    localparam logic [3:0] M_ERROR     = 4'd1;
    localparam logic [3:0] M_NUM_INT   = 4'd2;
    localparam logic [3:0] M_NUM_DOT   = 4'd3;
    localparam logic [3:0] M_NUM_FRAC  = 4'd4;
    localparam logic [3:0] M_NUM_EXP   = 4'd5;
    localparam logic [3:0] M_NUM_ESIGN = 4'd6;
    localparam logic [3:0] M_NUM_EDIG  = 4'd7;
    localparam logic [3:0] M_IDENT     = 4'd8;
    localparam logic [3:0] M_STR       = 4'd9;
    localparam logic [3:0] M_ESC       = 4'd10;
    localparam logic [3:0] M_HEX       = 4'd11;
    localparam logic [3:0] M_LOW_BS    = 4'd12;
    localparam logic [3:0] M_LOW_U     = 4'd13;
    localparam logic [3:0] M_LOW_HEX   = 4'd14;

    localparam logic [2:0] C_PUNCT = 3'd0;
    localparam logic [2:0] C_NUM   = 3'd1;
    localparam logic [2:0] C_IDENT = 3'd2;
    localparam logic [2:0] C_STR   = 3'd3;
    localparam logic [2:0] C_EOS   = 3'd4;
    localparam logic [2:0] C_ERR   = 3'd5;

    localparam logic [3:0] E_NONE      = 4'd0;
    localparam logic [3:0] E_BAD_CHAR  = 4'd1;
    localparam logic [3:0] E_STRAY     = 4'd2;
    localparam logic [3:0] E_BAD_SEQ   = 4'd3;
    localparam logic [3:0] E_BAD_CP    = 4'd4;
    localparam logic [3:0] E_BAD_NUM   = 4'd5;
    localparam logic [3:0] E_UNTERM    = 4'd6;
    localparam logic [3:0] E_CTRL      = 4'd7;
    localparam logic [3:0] E_BAD_ESC   = 4'd8;
    localparam logic [3:0] E_DANGLING  = 4'd9;
    localparam logic [3:0] E_MISS_LOW  = 4'd10;

    typedef struct packed {
        logic        kind;
        logic [7:0]  byte_value;
    } jtl_item_t;

    typedef struct packed {
        logic [2:0]  token_class;
        logic [20:0] code_point;
        logic        has_char;
        logic        token_first;
        logic        token_last;
        logic [3:0]  error_code;
        logic        run_last;
    } jtl_result_t;

endpackage

// ----- rtl/core/json_token_lexer_unit.sv -----
// ----------------------------------------------------------------------------
// JSON token lexer unit
// Streaming UTF-8 checking JSON-style lexer.
// ----------------------------------------------------------------------------
// The unit accepts one byte or end-of-stream item per cycle while the queue is
// not full and produces zero, one or two results per item; each result leaves
// on its own cycle, so the output side sets the sustained rate: one item per
// cycle while items give at most one result, less where items give two. A
// four-entry request queue between the lexer and the output stage absorbs stalls.
module json_token_lexer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // byte_value[7:0]
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // code_point[20:0], has_char[21], token_first[22],
                                  // token_last[23], error_code[27:24], zero[31:28]
    output logic [2:0]  m_tuser,  // token_class[2:0]
    output logic        m_tlast   // run_last
);

    jtl_pkg::jtl_item_t   item;
    jtl_pkg::jtl_result_t r0, r1, ro;
    logic                 q_full, q_push;
    logic [1:0]           q_count;

    assign item.kind       = s_tuser;
    assign item.byte_value = s_tdata;

    jtl_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_item(item), .q_full(q_full), .q_push(q_push), .q_count(q_count),
        .q_res0(r0), .q_res1(r1)
    );

    jtl_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_push(q_push), .q_count(q_count),
        .q_res0(r0), .q_res1(r1), .q_full(q_full), .out_valid(m_tvalid),
        .out_ready(m_tready), .out_res(ro)
    );

    assign m_tdata = {4'd0, ro.error_code, ro.token_last, ro.token_first,
                      ro.has_char, ro.code_point};
    assign m_tuser = ro.token_class;
    assign m_tlast = ro.run_last;

endmodule

// ----- rtl/core/jtl_front.sv -----
// ----------------------------------------------------------------------------
// JSON token lexer front end
// Lexes one input item per cycle while the queue is not full and writes up to
// two results, as one request, into the queue.
// ----------------------------------------------------------------------------
module jtl_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  jtl_pkg::jtl_item_t   in_item,
    input  logic                 q_full,
    output logic                 q_push,
    output logic [1:0]           q_count,
    output jtl_pkg::jtl_result_t q_res0,
    output jtl_pkg::jtl_result_t q_res1
);

    logic [3:0]  mode_reg, mode_next;
    logic [1:0]  rem_reg, rem_next;
    logic [1:0]  len_reg, len_next;
    logic [20:0] acc_reg, acc_next;
    logic [9:0]  hs_reg, hs_next;
    logic [15:0] hex_reg, hex_next;
    logic [2:0]  hcnt_reg, hcnt_next;

    jtl_pkg::jtl_result_t r [2];
    logic [1:0] n;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready && (n != 2'd0);
    assign q_count  = n;
    assign q_res0   = r[0];
    assign q_res1   = r[1];

    function automatic jtl_pkg::jtl_result_t mk(logic [2:0] c, logic [20:0] cp,
                                                logic h, logic f, logic l,
                                                logic [3:0] e);
        jtl_pkg::jtl_result_t o;
        o.token_class = c;
        o.code_point  = cp;
        o.has_char    = h;
        o.token_first = f;
        o.token_last  = l;
        o.error_code  = e;
        o.run_last    = 1'b0;
        return o;
    endfunction

    function automatic logic is_dig(logic [20:0] c);
        return c >= 21'h30 && c <= 21'h39;
    endfunction

    function automatic logic is_id(logic [20:0] c);
        return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A) ||
               c == 21'h5F || c == 21'h24;
    endfunction

    function automatic logic [4:0] hexv(logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
        return v;
    endfunction

    always_comb begin
        logic [7:0]  b;
        logic [3:0]  nm;
        logic        acc_m;
        logic [20:0] c;
        logic        have_c;
        logic [4:0]  h;
        logic [15:0] v;
        logic [2:0]  ic;
        logic        err;
        logic [3:0]  ecode;
        logic [20:0] na;

        mode_next = mode_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        acc_next  = acc_reg;
        hs_next   = hs_reg;
        hex_next  = hex_reg;
        hcnt_next = hcnt_reg;
        r[0] = mk(jtl_pkg::C_PUNCT, 21'd0, 1'b0, 1'b0, 1'b0, jtl_pkg::E_NONE);
        r[1] = r[0];
        n = 2'd0;
        b = in_item.byte_value;
        nm = jtl_pkg::M_IDLE;
        c = 21'd0;
        have_c = 1'b0;
        h = hexv(b);
        v = {hex_reg[11:0], h[3:0]};
        err = 1'b0;
        ecode = jtl_pkg::E_NONE;
        na = 21'd0;
        acc_m = mode_reg == jtl_pkg::M_NUM_INT || mode_reg == jtl_pkg::M_NUM_FRAC ||
                mode_reg == jtl_pkg::M_NUM_EDIG || mode_reg == jtl_pkg::M_IDENT;
        ic = (mode_reg == jtl_pkg::M_IDENT) ? jtl_pkg::C_IDENT : jtl_pkg::C_NUM;

        if (in_item.kind) begin
            if (mode_reg != jtl_pkg::M_ERROR) begin
                if (rem_reg != 2'd0) begin
                    r[0] = mk(jtl_pkg::C_ERR, 21'd0, 1'b0, 1'b1, 1'b1, jtl_pkg::E_BAD_SEQ);
                    n = 2'd1;
                end else if (acc_m) begin
                    r[0] = mk(ic, 21'd0, 1'b0, 1'b0, 1'b1, jtl_pkg::E_NONE);
                    n = 2'd1;
                end else if (mode_reg >= jtl_pkg::M_NUM_DOT &&
                             mode_reg <= jtl_pkg::M_NUM_ESIGN) begin
                    r[0] = mk(jtl_pkg::C_ERR, 21'd0, 1'b0, 1'b1, 1'b1, jtl_pkg::E_BAD_NUM);
                    n = 2'd1;
                end else if (mode_reg == jtl_pkg::M_STR) begin
                    r[0] = mk(jtl_pkg::C_ERR, 21'd0, 1'b0, 1'b1, 1'b1, jtl_pkg::E_UNTERM);
                    n = 2'd1;
                end else if (mode_reg == jtl_pkg::M_ESC || mode_reg == jtl_pkg::M_HEX) begin
                    r[0] = mk(jtl_pkg::C_ERR, 21'd0, 1'b0, 1'b1, 1'b1, jtl_pkg::E_BAD_ESC);
                    n = 2'd1;
                end else if (mode_reg >= jtl_pkg::M_LOW_BS) begin
                    r[0] = mk(jtl_pkg::C_ERR, 21'd0, 1'b0, 1'b1, 1'b1, jtl_pkg::E_MISS_LOW);
                    n = 2'd1;
                end
            end
            r[n[0]] = mk(jtl_pkg::C_EOS, 21'd0, 1'b0, 1'b1, 1'b1, jtl_pkg::E_NONE);
            n = n + 2'd1;
            mode_next = jtl_pkg::M_IDLE;
            rem_next = 2'd0; len_next = 2'd0; acc_next = 21'd0;
            hs_next = 10'd0; hex_next = 16'd0; hcnt_next = 3'd0;
        end else if (mode_reg == jtl_pkg::M_ERROR) begin
            n = 2'd0;
        end else if (mode_reg >= jtl_pkg::M_ESC) begin
            if (mode_reg == jtl_pkg::M_ESC) begin
                mode_next = jtl_pkg::M_STR;
                n = 2'd1;
                priority case (b)
                    8'h5C, 8'h22, 8'h2F: r[0] = mk(jtl_pkg::C_STR, 21'(b), 1'b1, 1'b0, 1'b0, jtl_pkg::E_NONE);
                    8'h62: r[0] = mk(jtl_pkg::C_STR, 21'd8, 1'b1, 1'b0, 1'b0, jtl_pkg::E_NONE);
                    8'h66: r[0] = mk(jtl_pkg::C_STR, 21'd12, 1'b1, 1'b0, 1'b0, jtl_pkg::E_NONE);
                    8'h6E: r[0] = mk(jtl_pkg::C_STR, 21'd10, 1'b1, 1'b0, 1'b0, jtl_pkg::E_NONE);
                    8'h72: r[0] = mk(jtl_pkg::C_STR, 21'd13, 1'b1, 1'b0, 1'b0, jtl_pkg::E_NONE);
                    8'h74: r[0] = mk(jtl_pkg::C_STR, 21'd9, 1'b1, 1'b0, 1'b0, jtl_pkg::E_NONE);
                    8'h75: begin
                        mode_next = jtl_pkg::M_HEX; hex_next = 16'd0; hcnt_next = 3'd0;
                        n = 2'd0;
                    end
                    default: begin err = 1'b1; ecode = jtl_pkg::E_BAD_ESC; end
                endcase
            end else if (mode_reg == jtl_pkg::M_LOW_BS) begin
                if (b != 8'h5C) begin err = 1'b1; ecode = jtl_pkg::E_MISS_LOW; end
                else mode_next = jtl_pkg::M_LOW_U;
            end else if (mode_reg == jtl_pkg::M_LOW_U) begin
                if (b != 8'h75) begin err = 1'b1; ecode = jtl_pkg::E_MISS_LOW; end
                else begin
                    mode_next = jtl_pkg::M_LOW_HEX; hex_next = 16'd0; hcnt_next = 3'd0;
                end
            end else if (h[4]) begin
                err = 1'b1; ecode = jtl_pkg::E_BAD_ESC;
            end else if (hcnt_reg != 3'd3) begin
                hex_next = v; hcnt_next = hcnt_reg + 3'd1;
            end else begin
                hex_next = 16'd0; hcnt_next = 3'd0;
                if (mode_reg == jtl_pkg::M_HEX) begin
                    if (v >= 16'hDC00 && v <= 16'hDFFF) begin
                        err = 1'b1; ecode = jtl_pkg::E_DANGLING;
                    end else if (v >= 16'hD800 && v <= 16'hDBFF) begin
                        hs_next = v[9:0]; mode_next = jtl_pkg::M_LOW_BS;
                    end else begin
                        mode_next = jtl_pkg::M_STR;
                        r[0] = mk(jtl_pkg::C_STR, 21'(v), 1'b1, 1'b0, 1'b0, jtl_pkg::E_NONE);
                        n = 2'd1;
                    end
                end else if (v < 16'hDC00 || v > 16'hDFFF) begin
                    err = 1'b1; ecode = jtl_pkg::E_MISS_LOW;
                end else begin
                    hs_next = 10'd0; mode_next = jtl_pkg::M_STR;
                    r[0] = mk(jtl_pkg::C_STR, {1'b0, hs_reg, v[9:0]} + 21'h10000,
                              1'b1, 1'b0, 1'b0, jtl_pkg::E_NONE);
                    n = 2'd1;
                end
            end
            if (err) begin
                r[0] = mk(jtl_pkg::C_ERR, 21'd0, 1'b0, 1'b1, 1'b1, ecode);
                n = 2'd1;
            end
        end else begin
            logic go;
            go = 1'b1;
            if (mode_reg >= jtl_pkg::M_NUM_INT && mode_reg <= jtl_pkg::M_IDENT) begin
                go = 1'b0;
                unique case (mode_reg)
                    jtl_pkg::M_NUM_INT: nm = is_dig(21'(b)) ? jtl_pkg::M_NUM_INT :
                        b == 8'h2E ? jtl_pkg::M_NUM_DOT :
                        (b == 8'h65 || b == 8'h45) ? jtl_pkg::M_NUM_EXP : jtl_pkg::M_IDLE;
                    jtl_pkg::M_NUM_DOT: nm = is_dig(21'(b)) ? jtl_pkg::M_NUM_FRAC : jtl_pkg::M_IDLE;
                    jtl_pkg::M_NUM_FRAC: nm = is_dig(21'(b)) ? jtl_pkg::M_NUM_FRAC :
                        (b == 8'h65 || b == 8'h45) ? jtl_pkg::M_NUM_EXP : jtl_pkg::M_IDLE;
                    jtl_pkg::M_NUM_EXP: nm = is_dig(21'(b)) ? jtl_pkg::M_NUM_EDIG :
                        (b == 8'h2B || b == 8'h2D) ? jtl_pkg::M_NUM_ESIGN : jtl_pkg::M_IDLE;
                    jtl_pkg::M_NUM_ESIGN, jtl_pkg::M_NUM_EDIG:
                        nm = is_dig(21'(b)) ? jtl_pkg::M_NUM_EDIG : jtl_pkg::M_IDLE;
                    default: nm = (is_id(21'(b)) || is_dig(21'(b))) ? jtl_pkg::M_IDENT
                                                                    : jtl_pkg::M_IDLE;
                endcase
                if (nm != jtl_pkg::M_IDLE) begin
                    r[0] = mk(ic, 21'(b), 1'b1, 1'b0, 1'b0, jtl_pkg::E_NONE);
                    n = 2'd1;
                    mode_next = nm;
                end else if (acc_m) begin
                    r[0] = mk(ic, 21'd0, 1'b0, 1'b0, 1'b1, jtl_pkg::E_NONE);
                    n = 2'd1;
                    mode_next = jtl_pkg::M_IDLE;
                    go = 1'b1;
                end else begin
                    err = 1'b1; ecode = jtl_pkg::E_BAD_NUM;
                end
            end else if (mode_reg != jtl_pkg::M_STR) begin
                mode_next = jtl_pkg::M_IDLE;
            end
            if (go) begin
                if (rem_reg != 2'd0) begin
                    if (b[7:6] != 2'b10) begin
                        err = 1'b1; ecode = jtl_pkg::E_BAD_SEQ;
                    end else begin
                        na = {acc_reg[14:0], b[5:0]};
                        acc_next = na;
                        rem_next = rem_reg - 2'd1;
                        if (rem_reg == 2'd1) begin
                            if (na < 21'h80 || (len_reg == 2'd3 && na < 21'h800) ||
                                (len_reg == 2'd0 && na < 21'h10000) ||
                                (na >= 21'hD800 && na <= 21'hDFFF) || na > 21'h10FFFF) begin
                                err = 1'b1; ecode = jtl_pkg::E_BAD_CP;
                            end else begin
                                len_next = 2'd0; acc_next = 21'd0;
                                c = na; have_c = 1'b1;
                            end
                        end
                    end
                end else if (!b[7]) begin
                    c = 21'(b); have_c = 1'b1;
                end else if (b <= 8'hBF) begin
                    err = 1'b1; ecode = jtl_pkg::E_STRAY;
                end else if (b <= 8'hDF) begin
                    acc_next = 21'(b[4:0]); len_next = 2'd2; rem_next = 2'd1;
                end else if (b <= 8'hEF) begin
                    acc_next = 21'(b[3:0]); len_next = 2'd3; rem_next = 2'd2;
                end else if (b <= 8'hF7) begin
                    acc_next = 21'(b[2:0]); len_next = 2'd0; rem_next = 2'd3;
                end else begin
                    err = 1'b1; ecode = jtl_pkg::E_BAD_SEQ;
                end
                if (have_c) begin
                    if (mode_next == jtl_pkg::M_STR) begin
                        if (c == 21'h22) begin
                            mode_next = jtl_pkg::M_IDLE;
                            r[n[0]] = mk(jtl_pkg::C_STR, 21'd0, 1'b0, 1'b0, 1'b1, jtl_pkg::E_NONE);
                            n = n + 2'd1;
                        end else if (c <= 21'h1F || c == 21'h7F) begin
                            err = 1'b1; ecode = jtl_pkg::E_CTRL;
                        end else if (c == 21'h5C) begin
                            mode_next = jtl_pkg::M_ESC;
                        end else begin
                            r[n[0]] = mk(jtl_pkg::C_STR, c, 1'b1, 1'b0, 1'b0, jtl_pkg::E_NONE);
                            n = n + 2'd1;
                        end
                    end else if (c == 21'h09 || c == 21'h0D || c == 21'h0A || c == 21'h20) begin
                        n = n;
                    end else if (c == 21'h5B || c == 21'h5D || c == 21'h7B || c == 21'h7D ||
                                 c == 21'h3A || c == 21'h2C) begin
                        r[n[0]] = mk(jtl_pkg::C_PUNCT, c, 1'b1, 1'b1, 1'b1, jtl_pkg::E_NONE);
                        n = n + 2'd1;
                    end else if (is_dig(c) || c == 21'h2B || c == 21'h2D) begin
                        mode_next = jtl_pkg::M_NUM_INT;
                        r[n[0]] = mk(jtl_pkg::C_NUM, c, 1'b1, 1'b1, 1'b0, jtl_pkg::E_NONE);
                        n = n + 2'd1;
                    end else if (is_id(c)) begin
                        mode_next = jtl_pkg::M_IDENT;
                        r[n[0]] = mk(jtl_pkg::C_IDENT, c, 1'b1, 1'b1, 1'b0, jtl_pkg::E_NONE);
                        n = n + 2'd1;
                    end else if (c == 21'h22) begin
                        mode_next = jtl_pkg::M_STR;
                        r[n[0]] = mk(jtl_pkg::C_STR, 21'd0, 1'b0, 1'b1, 1'b0, jtl_pkg::E_NONE);
                        n = n + 2'd1;
                    end else begin
                        err = 1'b1; ecode = jtl_pkg::E_BAD_CHAR;
                    end
                end
            end
            if (err) begin
                r[n[0]] = mk(jtl_pkg::C_ERR, 21'd0, 1'b0, 1'b1, 1'b1, ecode);
                n = n + 2'd1;
            end
        end
        if (err) begin
            mode_next = jtl_pkg::M_ERROR;
            rem_next = 2'd0; len_next = 2'd0; acc_next = 21'd0;
            hs_next = 10'd0; hex_next = 16'd0; hcnt_next = 3'd0;
        end
        if (n == 2'd1) r[0].run_last = 1'b1;
        if (n == 2'd2) r[1].run_last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= jtl_pkg::M_IDLE;
            rem_reg  <= 2'd0;
            len_reg  <= 2'd0;
            acc_reg  <= 21'd0;
            hs_reg   <= 10'd0;
            hex_reg  <= 16'd0;
            hcnt_reg <= 3'd0;
        end else if (in_valid && in_ready) begin
            mode_reg <= mode_next;
            rem_reg  <= rem_next;
            len_reg  <= len_next;
            acc_reg  <= acc_next;
            hs_reg   <= hs_next;
            hex_reg  <= hex_next;
            hcnt_reg <= hcnt_next;
        end
    end

    a_hcnt: assert property (@(posedge aclk) disable iff (!aresetn) hcnt_reg <= 3'd3)
        else $error("hex digit count out of range");
    a_mode: assert property (@(posedge aclk) disable iff (!aresetn) mode_reg != 4'd15)
        else $error("illegal lexer mode");
    a_push: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full) else $error("push into full queue");

endmodule

// ----- rtl/core/jtl_back.sv -----
// ----------------------------------------------------------------------------
// JSON token lexer back end
// Holds a short queue of requests (one to two results each) and sends the
// results out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module jtl_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_push,
    input  logic [1:0]           q_count,
    input  jtl_pkg::jtl_result_t q_res0,
    input  jtl_pkg::jtl_result_t q_res1,
    output logic                 q_full,
    output logic                 out_valid,
    input  logic                 out_ready,
    output jtl_pkg::jtl_result_t out_res
);

    jtl_pkg::jtl_result_t e0_reg [4];
    jtl_pkg::jtl_result_t e1_reg [4];
    logic                 two_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       half_reg;
    logic       pop, done;

    assign out_valid = cnt_reg != 3'd0;
    assign out_res   = half_reg ? e1_reg[rp_reg] : e0_reg[rp_reg];
    assign done      = out_valid && out_ready && (half_reg || !two_reg[rp_reg]);
    assign pop       = done;
    assign q_full    = cnt_reg == 3'd4;

    always_ff @(posedge aclk) begin
        if (q_push) begin
            e0_reg[wp_reg]  <= q_res0;
            e1_reg[wp_reg]  <= q_res1;
            two_reg[wp_reg] <= q_count == 2'd2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= 2'd0;
            rp_reg   <= 2'd0;
            cnt_reg  <= 3'd0;
            half_reg <= 1'b0;
        end else begin
            if (q_push) wp_reg <= wp_reg + 2'd1;
            if (pop) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(q_push) - 3'(pop);
            if (pop) half_reg <= 1'b0;
            else if (out_valid && out_ready) half_reg <= 1'b1;
        end
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 3'd4)
        else $error("queue count overflow");
    a_half: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg |-> out_valid) else $error("half-sent request without entry");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 3'd0) |-> !half_reg) else $error("empty queue mid-request");

endmodule
